// ----- rtl/core/sql_subset_tokenizer_assert.svh -----
// Assertion macros for the checker file.
`ifndef SQL_SUBSET_TOKENIZER_ASSERT_SVH
`define SQL_SUBSET_TOKENIZER_ASSERT_SVH

// Same-cycle implication under reset.
`define SSTK_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define SSTK_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sstk_pkg.sv -----
`default_nettype none

package sstk_pkg;

    // Record kinds
    localparam logic [1:0] REC_TEXT  = 2'd0;
    localparam logic [1:0] REC_END   = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    // Token kinds
    localparam logic [3:0] TOK_EOF    = 4'd0;
    localparam logic [3:0] TOK_IDENT  = 4'd1;
    localparam logic [3:0] TOK_STRING = 4'd2;
    localparam logic [3:0] TOK_NUMBER = 4'd3;
    localparam logic [3:0] TOK_COMMA  = 4'd4;
    localparam logic [3:0] TOK_LPAREN = 4'd5;
    localparam logic [3:0] TOK_RPAREN = 4'd6;
    localparam logic [3:0] TOK_SEMI   = 4'd7;
    localparam logic [3:0] TOK_STAR   = 4'd8;
    localparam logic [3:0] TOK_INSERT = 4'd9;
    localparam logic [3:0] TOK_EQUAL  = 4'd15;

    // Error kinds
    localparam logic [1:0] ERR_INVALID_CHAR = 2'd0;
    localparam logic [1:0] ERR_BAD_NUMBER   = 2'd1;
    localparam logic [1:0] ERR_OPEN_STRING  = 2'd2;

    // Most records one input byte can cause
    localparam int MAX_RECS = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] tok;
        logic [7:0] ch;
        logic [1:0] err;
    } rec_t;

    typedef struct packed {
        logic [1:0]               cnt;
        rec_t [MAX_RECS-1:0]      recs;
    } bundle_t;

    // One bundle with its valid flag, front to queue and queue to back
    typedef struct packed {
        logic    valid;
        bundle_t data;
    } beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/sstk_in_if.sv -----
`default_nettype none

interface sstk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sstk_out_if.sv -----
`default_nettype none

interface sstk_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] record_kind;
    logic [3:0] token_kind;
    logic [7:0] char_out;
    logic [1:0] error_kind;
    logic       last_of_run;

    modport source (output valid, output record_kind, output token_kind, output char_out,
                    output error_kind, output last_of_run, input ready);
    modport sink   (input valid, input record_kind, input token_kind, input char_out,
                    input error_kind, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sstk_front.sv -----
`default_nettype none

// Lexer front: takes one byte per cycle while the queue has room, updates lexer state and
// pushes the bundle of records the byte causes into the queue.
module sstk_front
    import sstk_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sstk_in_if.sink     text,
    input  wire logic   push_ready,
    output beat_t       push
);

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_MINUS, M_NUMBER, M_NUMDOT, M_STRING, M_STRQUOTE, M_DEAD
    } mode_t;

    localparam int         KW_COUNT = 6;
    localparam logic [5:0] ALL_HITS = 6'h3F;

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;

    // Character classes
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'h20 : c;
    endfunction

    // Keyword table: INSERT INTO VALUES SELECT FROM WHERE
    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] r;
        case (k)
            3'd0:    r = 3'd6;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd6;
            3'd3:    r = 3'd6;
            3'd4:    r = 3'd4;
            3'd5:    r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
        logic [47:0] w;
        logic [7:0]  r;
        case (k)
            3'd0:    w = "INSERT";
            3'd1:    w = {"INTO", 16'h0};
            3'd2:    w = "VALUES";
            3'd3:    w = "SELECT";
            3'd4:    w = {"FROM", 16'h0};
            3'd5:    w = {"WHERE", 8'h0};
            default: w = '0;
        endcase
        r = '0;
        if (pos < 3'd6)
        begin
            r = w[8 * (3'd5 - pos) +: 8];
        end
        return r;
    endfunction

    // Keep the keywords still matching after one more letter
    function automatic logic [5:0] kw_match(input logic [5:0] hits, input logic [2:0] len,
                                            input logic [7:0] up);
        logic [5:0] m;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            m[k] = hits[k] && (len < kw_len(3'(k))) && (kw_char(3'(k), len) == up);
        end
        return m;
    endfunction

    function automatic logic [3:0] word_kind(input logic [5:0] hits, input logic [2:0] len);
        logic [3:0] r;
        r = TOK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (hits[k] && (len == kw_len(3'(k))))
            begin
                r = TOK_INSERT + 4'(k);
            end
        end
        return r;
    endfunction

    function automatic rec_t mk_rec(input logic [1:0] kind, input logic [3:0] tok,
                                    input logic [7:0] ch, input logic [1:0] err);
        rec_t r;
        r.kind = kind;
        r.tok  = tok;
        r.ch   = ch;
        r.err  = err;
        return r;
    endfunction

    mode_t      mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic [5:0] hits_reg, hits_next;
    logic [2:0] len_reg, len_next;
    logic       dot_reg, dot_next;

    rec_t [MAX_RECS-1:0] recs;
    logic [1:0]          n;
    logic                do_start;
    logic                ok;
    logic [3:0]          sym;
    logic [7:0]          c;
    logic                accept;

    assign c          = text.char_in;
    assign text.ready = push_ready;
    assign accept     = text.valid && push_ready;

    // Next lexer state and records for this byte
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        hits_next = hits_reg;
        len_next  = len_reg;
        dot_next  = dot_reg;
        recs      = '0;
        n         = 2'd0;
        do_start  = 1'b0;
        ok        = 1'b1;
        sym       = TOK_EOF;

        if (text.end_of_text)
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    recs[n] = mk_rec(REC_END, word_kind(hits_reg, len_reg), 8'h0, 2'd0);
                    n = n + 2'd1;
                end
                M_NUMBER:
                begin
                    recs[n] = mk_rec(REC_END, TOK_NUMBER, 8'h0, 2'd0);
                    n = n + 2'd1;
                end
                M_STRQUOTE:
                begin
                    recs[n] = mk_rec(REC_END, TOK_STRING, 8'h0, 2'd0);
                    n = n + 2'd1;
                end
                M_MINUS:
                begin
                    recs[n] = mk_rec(REC_ERROR, TOK_EOF, 8'h0, ERR_INVALID_CHAR);
                    n = n + 2'd1;
                    ok = 1'b0;
                end
                M_NUMDOT:
                begin
                    recs[n] = mk_rec(REC_ERROR, TOK_EOF, 8'h0, ERR_BAD_NUMBER);
                    n = n + 2'd1;
                    ok = 1'b0;
                end
                M_STRING:
                begin
                    recs[n] = mk_rec(REC_ERROR, TOK_EOF, 8'h0, ERR_OPEN_STRING);
                    n = n + 2'd1;
                    ok = 1'b0;
                end
                M_DEAD:
                begin
                    ok = 1'b0;
                end
                default:
                begin
                end
            endcase
            if (ok)
            begin
                recs[n] = mk_rec(REC_END, TOK_EOF, 8'h0, 2'd0);
                n = n + 2'd1;
            end
            mode_next = M_IDLE;
            held_next = 8'h0;
            hits_next = ALL_HITS;
            len_next  = 3'd0;
            dot_next  = 1'b0;
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c) || (c == CH_UNDER))
                    begin
                        hits_next = kw_match(hits_reg, len_reg, to_upper(c));
                        len_next  = (len_reg == 3'd7) ? 3'd7 : len_reg + 3'd1;
                        recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        recs[n] = mk_rec(REC_END, word_kind(hits_reg, len_reg), 8'h0, 2'd0);
                        n = n + 2'd1;
                        hits_next = ALL_HITS;
                        len_next  = 3'd0;
                        do_start  = 1'b1;
                    end
                end
                M_MINUS:
                begin
                    if (is_digit(c))
                    begin
                        recs[n] = mk_rec(REC_TEXT, TOK_EOF, held_reg, 2'd0);
                        n = n + 2'd1;
                        recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                        n = n + 2'd1;
                        dot_next  = 1'b0;
                        mode_next = M_NUMBER;
                    end
                    else
                    begin
                        recs[n] = mk_rec(REC_ERROR, TOK_EOF, 8'h0, ERR_INVALID_CHAR);
                        n = n + 2'd1;
                        mode_next = M_DEAD;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                        n = n + 2'd1;
                    end
                    else if ((c == CH_DOT) && !dot_reg)
                    begin
                        recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                        n = n + 2'd1;
                        dot_next  = 1'b1;
                        mode_next = M_NUMDOT;
                    end
                    else
                    begin
                        recs[n] = mk_rec(REC_END, TOK_NUMBER, 8'h0, 2'd0);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_NUMDOT:
                begin
                    if (is_digit(c))
                    begin
                        recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                        n = n + 2'd1;
                        mode_next = M_NUMBER;
                    end
                    else
                    begin
                        recs[n] = mk_rec(REC_ERROR, TOK_EOF, 8'h0, ERR_BAD_NUMBER);
                        n = n + 2'd1;
                        mode_next = M_DEAD;
                    end
                end
                M_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        mode_next = M_STRQUOTE;
                    end
                    else
                    begin
                        recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                        n = n + 2'd1;
                    end
                end
                M_STRQUOTE:
                begin
                    if (c == CH_QUOTE)
                    begin
                        recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                        n = n + 2'd1;
                        mode_next = M_STRING;
                    end
                    else
                    begin
                        recs[n] = mk_rec(REC_END, TOK_STRING, 8'h0, 2'd0);
                        n = n + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_DEAD:
                begin
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase

            // First byte of a new token, possibly right after a closed one
            if (do_start)
            begin
                mode_next = M_IDLE;
                case (c)
                    CH_COMMA:  sym = TOK_COMMA;
                    CH_LPAREN: sym = TOK_LPAREN;
                    CH_RPAREN: sym = TOK_RPAREN;
                    CH_SEMI:   sym = TOK_SEMI;
                    CH_STAR:   sym = TOK_STAR;
                    CH_EQUAL:  sym = TOK_EQUAL;
                    default:   sym = TOK_EOF;
                endcase
                if (is_space(c))
                begin
                end
                else if (is_alpha(c) || (c == CH_UNDER))
                begin
                    hits_next = kw_match(ALL_HITS, 3'd0, to_upper(c));
                    len_next  = 3'd1;
                    recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                    n = n + 2'd1;
                    mode_next = M_IDENT;
                end
                else if (is_digit(c))
                begin
                    dot_next = 1'b0;
                    recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                    n = n + 2'd1;
                    mode_next = M_NUMBER;
                end
                else if (c == CH_MINUS)
                begin
                    held_next = c;
                    mode_next = M_MINUS;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = M_STRING;
                end
                else if (sym != TOK_EOF)
                begin
                    recs[n] = mk_rec(REC_TEXT, TOK_EOF, c, 2'd0);
                    n = n + 2'd1;
                    recs[n] = mk_rec(REC_END, sym, 8'h0, 2'd0);
                    n = n + 2'd1;
                end
                else
                begin
                    recs[n] = mk_rec(REC_ERROR, TOK_EOF, 8'h0, ERR_INVALID_CHAR);
                    n = n + 2'd1;
                    mode_next = M_DEAD;
                end
            end
        end
    end

    // Bytes that cause no record push nothing
    always_comb
    begin
        push.valid     = accept && (n != 2'd0);
        push.data.cnt  = n;
        push.data.recs = recs;
    end

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            held_reg <= 8'h0;
            hits_reg <= ALL_HITS;
            len_reg  <= 3'd0;
            dot_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            hits_reg <= hits_next;
            len_reg  <= len_next;
            dot_reg  <= dot_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sstk_queue.sv -----
`default_nettype none

// Small bundle queue between the lexer front and the record back end.
module sstk_queue
    import sstk_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire beat_t push,
    output logic       push_ready,
    output beat_t      pop,
    input  wire logic  pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bundle_t            slots [DEPTH];
    logic [PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    always_comb
    begin
        pop.valid = (count_reg != '0);
        pop.data  = slots[rptr_reg];
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wptr_reg] <= push.data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sstk_back.sv -----
`default_nettype none

// Record back end: unrolls one bundle into records, one per cycle unless tokens stalls,
// through a registered output stage.
module sstk_back
    import sstk_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire beat_t  pop,
    output logic        pop_ready,
    sstk_out_if.source  tokens
);

    bundle_t    hold_reg;
    logic       hold_valid_reg;
    logic [1:0] idx_reg;
    logic       out_valid_reg;
    rec_t       out_rec_reg;
    logic       out_last_reg;

    logic       load;
    logic       is_last;
    logic       hold_done;
    logic       take;

    assign load      = hold_valid_reg && (!out_valid_reg || tokens.ready);
    assign is_last   = (idx_reg == hold_reg.cnt - 2'd1);
    assign hold_done = load && is_last;
    assign pop_ready = !hold_valid_reg || hold_done;
    assign take      = pop.valid && pop_ready;

    // Bundle holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
            idx_reg        <= 2'd0;
        end
        else if (hold_done)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= pop.data;
        end
    end

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tokens.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_rec_reg  <= hold_reg.recs[idx_reg];
            out_last_reg <= is_last;
        end
    end

    assign tokens.valid       = out_valid_reg;
    assign tokens.record_kind = out_rec_reg.kind;
    assign tokens.token_kind  = out_rec_reg.tok;
    assign tokens.char_out    = out_rec_reg.ch;
    assign tokens.error_kind  = out_rec_reg.err;
    assign tokens.last_of_run = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sql_subset_tokenizer.sv -----
// Channel   Dir  Payload                                                   Item
// text      in   char_in[7:0], end_of_text                                 one text byte
// tokens    out  record_kind, token_kind, char_out, error_kind, last_of_run one record
//
// One byte is taken per cycle while the bundle queue has room; each byte
// gives zero to three records; the back end sends one record per cycle unless stalled.
// A byte's first record passes the queue, the hold register and the output register.
// The single record output limits the flow: bursts queue up in QUEUE_DEPTH bundles.
// Reset is asynchronous and active low; lexer state returns to idle at end of text.
// A stall on tokens backs up the queue and then drops text.ready.
`default_nettype none

module sql_subset_tokenizer
    import sstk_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sstk_in_if.sink     text,
    sstk_out_if.source  tokens
);

    beat_t push;
    beat_t pop;
    logic  push_ready;
    logic  pop_ready;

    sstk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push_ready (push_ready),
        .push       (push)
    );

    sstk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    sstk_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .tokens    (tokens)
    );

endmodule

`default_nettype wire

// ----- rtl/core/sstk_checker.sv -----
`default_nettype none

`include "sql_subset_tokenizer_assert.svh"

// Port-level checks on the record stream.
module sstk_checker
    import sstk_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       valid,
    input wire logic       ready,
    input wire logic [1:0] record_kind,
    input wire logic [3:0] token_kind,
    input wire logic [7:0] char_out,
    input wire logic [1:0] error_kind,
    input wire logic       last_of_run
);

    // A stalled record holds
    `SSTK_ASSERT_NEXT(a_stall_hold, clk, rst_n, valid && !ready, valid && $stable(record_kind) && $stable(token_kind) && $stable(char_out) && $stable(error_kind) && $stable(last_of_run), "stalled record changed")

    // An error is always the last record of its byte
    `SSTK_ASSERT_IMPLY(a_err_last, clk, rst_n, valid && (record_kind == REC_ERROR), last_of_run, "error not last of run")

    // The EOF token closes its byte's records
    `SSTK_ASSERT_IMPLY(a_eof_last, clk, rst_n, valid && (record_kind == REC_END) && (token_kind == TOK_EOF), last_of_run, "eof not last of run")

    // Only text records carry a character
    `SSTK_ASSERT_IMPLY(a_char_zero, clk, rst_n, valid && (record_kind != REC_TEXT), (char_out == 8'h0) && ((record_kind == REC_ERROR) || (error_kind == 2'd0)), "stray payload on non-text record")

endmodule

bind sql_subset_tokenizer sstk_checker u_sstk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (tokens.valid),
    .ready       (tokens.ready),
    .record_kind (tokens.record_kind),
    .token_kind  (tokens.token_kind),
    .char_out    (tokens.char_out),
    .error_kind  (tokens.error_kind),
    .last_of_run (tokens.last_of_run)
);

`default_nettype wire

// ----- tb/sql_subset_tokenizer_tb.sv -----
`timescale 1ns / 100ps

module sql_subset_tokenizer_tb;
    import sstk_pkg::*;

    localparam int unsigned RANDOM_BYTES = 70;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned HOLD_AFTER   = 40;

    // Lexer modes of the predictor
    typedef enum logic [2:0] {
        LX_IDLE,
        LX_WORD,
        LX_MINUS,
        LX_NUM,
        LX_NUMDOT,
        LX_STR,
        LX_STRQ,
        LX_DEAD
    } lex_mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] tok;
        logic [7:0] ch;
        logic [1:0] err;
        logic       last;
    } tok_rec_t;

    typedef struct {
        logic [7:0]  ch;
        logic        eot;
        int unsigned gap;
    } text_item_t;

    logic clk;
    logic rst_n;

    sstk_in_if  text_ch ();
    sstk_out_if tok_ch ();

    sql_subset_tokenizer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (tok_ch)
    );

    string keywords [6] = '{"INSERT", "INTO", "VALUES", "SELECT", "FROM", "WHERE"};

    // Lexer state of the predictor
    lex_mode_t  lx_mode;
    logic [7:0] lx_held;
    logic [5:0] kw_hits;
    logic [2:0] word_len;
    logic       dot_seen;

    text_item_t  pending_text [$];
    tok_rec_t    step_recs [$];
    tok_rec_t    expected_recs [$];

    text_item_t  next_text;
    bit          next_loaded;
    int unsigned idle_left;
    bit          text_taken;
    int unsigned stall_left;
    int unsigned calm_left;
    bit          hold_off;

    int unsigned bytes_queued;
    int unsigned bytes_accepted;
    int unsigned recs_seen;
    int unsigned keyword_ends;
    int unsigned error_recs;
    int unsigned fail_count;
    int unsigned cycle_count;

    // Character classes
    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [3:0] symbol_kind(logic [7:0] c);
        case (c)
            ",":     return TOK_COMMA;
            "(":     return TOK_LPAREN;
            ")":     return TOK_RPAREN;
            ";":     return TOK_SEMI;
            "*":     return TOK_STAR;
            "=":     return TOK_EQUAL;
            default: return TOK_EOF;
        endcase
    endfunction

    task automatic emit(logic [1:0] kind, logic [3:0] tok, logic [7:0] ch, logic [1:0] err);
        tok_rec_t r;
        r.kind = kind;
        r.tok  = tok;
        r.ch   = ch;
        r.err  = err;
        r.last = 1'b0;
        step_recs.push_back(r);
    endtask

    task automatic word_clear();
        kw_hits  = 6'h3F;
        word_len = 3'd0;
    endtask

    task automatic lexer_clear();
        lx_mode  = LX_IDLE;
        lx_held  = 8'd0;
        dot_seen = 1'b0;
        word_clear();
    endtask

    // Narrow the keyword candidates by one more character
    task automatic word_add(logic [7:0] c);
        logic [7:0] up;
        int         k;
        up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        for (k = 0; k < 6; k++)
        begin
            if (word_len >= keywords[k].len() || 8'(keywords[k][word_len]) != up)
                kw_hits[k] = 1'b0;
        end
        if (word_len < 3'd7)
            word_len++;
    endtask

    function automatic logic [3:0] word_kind();
        int k;
        for (k = 0; k < 6; k++)
        begin
            if (kw_hits[k] && word_len == keywords[k].len())
                return 4'(TOK_INSERT + k);
        end
        return TOK_IDENT;
    endfunction

    task automatic lex_error(logic [1:0] err);
        emit(REC_ERROR, TOK_EOF, 8'd0, err);
        lx_mode = LX_DEAD;
    endtask

    // First byte after a token boundary
    task automatic lex_start(logic [7:0] c);
        logic [3:0] sym;
        sym = symbol_kind(c);
        lx_mode = LX_IDLE;
        if (is_space(c))
            lx_mode = LX_IDLE;
        else if (is_alpha(c) || c == "_")
        begin
            word_clear();
            word_add(c);
            emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
            lx_mode = LX_WORD;
        end
        else if (is_digit(c))
        begin
            dot_seen = 1'b0;
            emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
            lx_mode = LX_NUM;
        end
        else if (c == "-")
        begin
            lx_held = c;
            lx_mode = LX_MINUS;
        end
        else if (c == "'")
            lx_mode = LX_STR;
        else if (sym != TOK_EOF)
        begin
            emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
            emit(REC_END, sym, 8'd0, ERR_INVALID_CHAR);
        end
        else
            lex_error(ERR_INVALID_CHAR);
    endtask

    // Predict the records of one accepted byte and queue them
    task automatic lex_byte(logic [7:0] c, logic eot);
        bit ok;
        step_recs.delete();
        if (eot)
        begin
            ok = 1'b1;
            case (lx_mode)
                LX_WORD:   emit(REC_END, word_kind(), 8'd0, ERR_INVALID_CHAR);
                LX_NUM:    emit(REC_END, TOK_NUMBER, 8'd0, ERR_INVALID_CHAR);
                LX_STRQ:   emit(REC_END, TOK_STRING, 8'd0, ERR_INVALID_CHAR);
                LX_MINUS:
                begin
                    emit(REC_ERROR, TOK_EOF, 8'd0, ERR_INVALID_CHAR);
                    ok = 1'b0;
                end
                LX_NUMDOT:
                begin
                    emit(REC_ERROR, TOK_EOF, 8'd0, ERR_BAD_NUMBER);
                    ok = 1'b0;
                end
                LX_STR:
                begin
                    emit(REC_ERROR, TOK_EOF, 8'd0, ERR_OPEN_STRING);
                    ok = 1'b0;
                end
                LX_DEAD:   ok = 1'b0;
                default:   ok = 1'b1;
            endcase
            if (ok)
                emit(REC_END, TOK_EOF, 8'd0, ERR_INVALID_CHAR);
            lexer_clear();
        end
        else
        begin
            case (lx_mode)
                LX_WORD:
                begin
                    if (is_word(c))
                    begin
                        word_add(c);
                        emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
                    end
                    else
                    begin
                        emit(REC_END, word_kind(), 8'd0, ERR_INVALID_CHAR);
                        word_clear();
                        lex_start(c);
                    end
                end
                LX_MINUS:
                begin
                    if (is_digit(c))
                    begin
                        emit(REC_TEXT, TOK_EOF, lx_held, ERR_INVALID_CHAR);
                        emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
                        dot_seen = 1'b0;
                        lx_mode = LX_NUM;
                    end
                    else
                        lex_error(ERR_INVALID_CHAR);
                end
                LX_NUM:
                begin
                    if (is_digit(c))
                        emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
                    else if (c == "." && !dot_seen)
                    begin
                        emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
                        dot_seen = 1'b1;
                        lx_mode = LX_NUMDOT;
                    end
                    else
                    begin
                        emit(REC_END, TOK_NUMBER, 8'd0, ERR_INVALID_CHAR);
                        lex_start(c);
                    end
                end
                LX_NUMDOT:
                begin
                    if (is_digit(c))
                    begin
                        emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
                        lx_mode = LX_NUM;
                    end
                    else
                        lex_error(ERR_BAD_NUMBER);
                end
                LX_STR:
                begin
                    if (c == "'")
                        lx_mode = LX_STRQ;
                    else
                        emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
                end
                LX_STRQ:
                begin
                    if (c == "'")
                    begin
                        emit(REC_TEXT, TOK_EOF, c, ERR_INVALID_CHAR);
                        lx_mode = LX_STR;
                    end
                    else
                    begin
                        emit(REC_END, TOK_STRING, 8'd0, ERR_INVALID_CHAR);
                        lex_start(c);
                    end
                end
                LX_DEAD: lx_mode = LX_DEAD;
                default: lex_start(c);
            endcase
        end
        if (step_recs.size() != 0)
            step_recs[step_recs.size() - 1].last = 1'b1;
        foreach (step_recs[i])
            expected_recs.push_back(step_recs[i]);
    endtask

    // Idle lengths: mostly none, some short, a few long
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 24);
    endfunction

    task automatic push_byte(logic [7:0] c, logic eot, bit calm);
        text_item_t it;
        it.ch  = c;
        it.eot = eot;
        it.gap = calm ? 0 : pick_idle();
        pending_text.push_back(it);
        bytes_queued++;
    endtask

    task automatic push_text(string s, bit calm);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(8'(s[i]), 1'b0, calm);
    endtask

    function automatic logic [7:0] pick_from(string set);
        return 8'(set[$urandom_range(0, set.len() - 1)]);
    endfunction

    function automatic logic [7:0] rand_case(logic [7:0] c);
        if ($urandom_range(0, 1) == 1 && c >= "A" && c <= "Z")
            return c + 8'd32;
        return c;
    endfunction

    // Separator between fragments; none at all tests a token boundary
    task automatic push_gap_space(bit calm);
        int n;
        int i;
        n = $urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 2);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1) == 1)
                push_byte(" ", 1'b0, calm);
            else
                push_byte(8'($urandom_range(9, 13)), 1'b0, calm);
        end
    endtask

    // One well-formed-ish statement of random fragments, closed by end of text
    task automatic push_statement();
        bit    calm;
        int    n_frags;
        int    f;
        int    i;
        int    n;
        int    sel;
        string kw;
        calm = ($urandom_range(0, 2) == 0);
        n_frags = $urandom_range(3, 9);
        for (f = 0; f < n_frags; f++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 25)
            begin
                // keyword, sometimes cut short or extended
                kw = keywords[$urandom_range(0, 5)];
                n = kw.len();
                if ($urandom_range(0, 4) == 0)
                    n = n - 1;
                for (i = 0; i < n; i++)
                    push_byte(rand_case(8'(kw[i])), 1'b0, calm);
                if ($urandom_range(0, 4) == 0)
                    push_byte(pick_from("X_7s"), 1'b0, calm);
            end
            else if (sel < 40)
            begin
                // identifier, short or long
                push_byte(pick_from("_abcxyzQRST"), 1'b0, calm);
                n = $urandom_range(0, 9);
                for (i = 0; i < n; i++)
                    push_byte(pick_from("abcdefghijklmnopqrstuvwxyzMNOP0123456789_"), 1'b0, calm);
            end
            else if (sel < 58)
            begin
                // number, with lone minus, dangling dot and second dot forms
                n = $urandom_range(0, 9);
                if (n < 2)
                    push_byte("-", 1'b0, calm);
                if (n != 1)
                begin
                    for (i = 0; i < $urandom_range(1, 3); i++)
                        push_byte(pick_from("0123456789"), 1'b0, calm);
                    if (n >= 6)
                    begin
                        push_byte(".", 1'b0, calm);
                        if (n != 8)
                        begin
                            for (i = 0; i < $urandom_range(1, 2); i++)
                                push_byte(pick_from("0123456789"), 1'b0, calm);
                        end
                        if (n == 9)
                            push_byte(".", 1'b0, calm);
                    end
                end
            end
            else if (sel < 70)
            begin
                // quoted string with doubled quotes and raw bytes
                push_byte("'", 1'b0, calm);
                n = $urandom_range(0, 5);
                for (i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0:       push_text("''", calm);
                        1:       push_byte(8'($urandom_range(128, 255)), 1'b0, calm);
                        2:       push_byte(8'($urandom_range(0, 38)), 1'b0, calm);
                        default: push_byte(8'($urandom_range(40, 127)), 1'b0, calm);
                    endcase
                end
                if ($urandom_range(0, 9) != 0)
                    push_byte("'", 1'b0, calm);
            end
            else if (sel < 88)
                push_byte(pick_from(",()*;="), 1'b0, calm);
            else
                push_byte(8'($urandom_range(0, 255)), 1'b0, calm);
            push_gap_space(calm);
        end
        push_byte(8'($urandom_range(0, 255)), 1'b1, calm);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d records outstanding",
                     cycle_count, expected_recs.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Accepted bytes feed the predictor
    always @(posedge clk)
    begin
        text_taken = 1'b0;
        if (rst_n && text_ch.valid && text_ch.ready)
        begin
            text_taken = 1'b1;
            lex_byte(text_ch.char_in, text_ch.end_of_text);
            bytes_accepted++;
        end
    end

    // Text driver: each byte waits out its own gap before it is offered
    always @(negedge clk)
    begin
        if (rst_n && (!text_ch.valid || text_taken))
        begin
            if (!next_loaded && pending_text.size() != 0)
            begin
                next_text = pending_text.pop_front();
                next_loaded = 1'b1;
                idle_left = next_text.gap;
            end
            if (next_loaded && idle_left == 0)
            begin
                text_ch.valid       <= 1'b1;
                text_ch.char_in     <= next_text.ch;
                text_ch.end_of_text <= next_text.eot;
                next_loaded = 1'b0;
            end
            else
            begin
                text_ch.valid <= 1'b0;
                if (next_loaded)
                    idle_left--;
            end
        end
    end

    // Token receiver: random stalls, calm stretches and one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off)
                tok_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                tok_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                tok_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 39) == 0)
                    calm_left = $urandom_range(20, 60);
                else
                    stall_left = pick_idle();
            end
        end
    end

    // Long output hold-off while text keeps coming
    initial
    begin
        hold_off = 1'b0;
        wait (bytes_accepted >= HOLD_AFTER);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Record checker
    always @(posedge clk)
    begin
        if (rst_n && tok_ch.valid && tok_ch.ready)
        begin
            recs_seen++;
            if (tok_ch.record_kind == REC_ERROR)
                error_recs++;
            if (tok_ch.record_kind == REC_END && tok_ch.token_kind >= TOK_INSERT
                && tok_ch.token_kind != TOK_EQUAL)
                keyword_ends++;
            if (expected_recs.size() == 0)
            begin
                $error("unexpected record: kind %0d token %0d char %0d error %0d",
                       tok_ch.record_kind, tok_ch.token_kind, tok_ch.char_out,
                       tok_ch.error_kind);
                fail_count++;
            end
            else
            begin
                check_field("record_kind", expected_recs[0].kind, tok_ch.record_kind);
                check_field("token_kind", expected_recs[0].tok, tok_ch.token_kind);
                check_field("char_out", expected_recs[0].ch, tok_ch.char_out);
                check_field("error_kind", expected_recs[0].err, tok_ch.error_kind);
                check_field("last_of_run", expected_recs[0].last, tok_ch.last_of_run);
                void'(expected_recs.pop_front());
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        text_ch.valid       = 1'b0;
        text_ch.char_in     = 8'd0;
        text_ch.end_of_text = 1'b0;
        tok_ch.ready        = 1'b0;
        next_loaded         = 1'b0;
        idle_left           = 0;
        text_taken          = 1'b0;
        stall_left          = 0;
        calm_left           = 0;
        bytes_queued        = 0;
        bytes_accepted      = 0;
        recs_seen           = 0;
        keyword_ends        = 0;
        error_recs          = 0;
        fail_count          = 0;
        cycle_count         = 0;
        lexer_clear();
        rst_n = 1'b0;

        // Directed: keyword in mixed case, symbols, signed decimal,
        // doubled quote and a string closed right before end of text
        push_text("Where=-7.5,'a''b'", 1'b1);
        push_byte(8'h5A, 1'b1, 1'b1);
        // NUL is an invalid character, then end of text gives nothing
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1);
        // top byte inside a string that never closes
        push_byte("'", 1'b0, 1'b1);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'h00, 1'b1, 1'b1);

        // Random statements
        while (bytes_queued < 23 + RANDOM_BYTES)
            push_statement();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (bytes_accepted == bytes_queued);
        while (expected_recs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Lexed %0d text bytes into %0d records in %0d cycles",
                 bytes_accepted, recs_seen, cycle_count);
        $display("%0d keyword tokens and %0d error records, output held off %0d cycles once",
                 keyword_ends, error_recs, HOLD_CYCLES);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
